FILE: rtl/lru_pr_pkg.sv
// ----------------------------------------------------------------------------
// lru_pr_pkg
// Shared types and fixed field widths for the LRU page replacement engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lru_pr_pkg;

  localparam int PAGE_W  = 16;
  localparam int SLOT_W  = 4;
  localparam int FAULT_W = 32;
  localparam int CFG_W   = 5;
  localparam int OUT_W   = 56;

  localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } lru_state_t;

endpackage

`default_nettype wire

FILE: rtl/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// LRU page replacement engine: looks up one page reference, fills a free
// frame or replaces the least recently used one, and reports the outcome.
// ----------------------------------------------------------------------------
// Usage
//   s_axis: one page reference per transfer, page number in tdata[15:0].
//   m_axis: one result per reference (hit, frame slot, evicted page, faults).
//   cfg_wr_en/cfg_wr_data: frames_in_use, written while the engine is idle.
// Timing
//   A new reference is taken only in the idle state. The engine then walks
//   the frame table one entry a cycle through the single page memory read
//   port (read data is registered), and finishes in an update state. The
//   result is registered and appears the cycle after the update.
// Reset
//   All frames empty, recency ranks and fault count zero, frames_in_use 16.
//   The page memory is not cleared; entries are only compared once valid.
// Stall
//   A new reference is accepted while a result waits; if the receiver still
//   holds the previous result at update time, the engine waits there.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement
  import lru_pr_pkg::*;
#(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [PAGE_W-1:0]  s_axis_tdata,   // page_number
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [OUT_W-1:0]        m_axis_tdata,   // hit, frame_slot, evicted_valid,
                                                  // evicted_page, fault_total
  input  wire logic               cfg_wr_en,
  input  wire logic [CFG_W-1:0]   cfg_wr_data
);

  localparam int SW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FW   = $clog2(MAX_FRAMES + 1);
  localparam int EW   = (FW > CFG_W) ? FW : CFG_W;
  localparam logic [SW-1:0] LAST = SW'(MAX_FRAMES - 1);
  localparam logic [EW-1:0] MAX_EXT = EW'(MAX_FRAMES);
  localparam logic [EW-1:0] ONE_EXT = EW'(1);

  lru_state_t state, state_next;

  logic [CFG_W-1:0]     frames_in_use;
  logic [PAGE_BITS-1:0] frame_page [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] frame_valid;
  logic [SW-1:0]        recency_rank [MAX_FRAMES];
  logic [FW-1:0]        frames_filled;
  logic [FAULT_W-1:0]   fault_counter;

  logic [PAGE_BITS-1:0] page_in;
  logic [PAGE_BITS-1:0] page;
  logic [SW-1:0]        idx;
  logic                 issue_done;
  logic                 p_vld;
  logic [SW-1:0]        p_idx;
  logic [PAGE_BITS-1:0] rd_page;

  logic                 hit_found;
  logic [SW-1:0]        hit_slot;
  logic [SW-1:0]        hit_rank;
  logic                 vic_found;
  logic [SW-1:0]        vic_slot;
  logic [SW-1:0]        vic_rank;
  logic [PAGE_BITS-1:0] vic_page;

  logic                 upd_go;
  logic [EW-1:0]        cfg_ext;
  logic [EW-1:0]        eff_frames;
  logic                 fill_ok;
  logic                 limit_all;
  logic [SW-1:0]        limit;
  logic [SW-1:0]        new_slot;
  logic                 ev_valid;
  logic                 set_valid;
  logic [FAULT_W-1:0]   fault_next;
  logic [PAGE_W-1:0]    ev_page16;
  logic [SLOT_W-1:0]    slot4;

  // page number truncated or zero-extended to the stored width
  for (genvar j = 0; j < PAGE_BITS; j++) begin : g_page_in
    if (j < PAGE_W) begin : g_bit
      assign page_in[j] = s_axis_tdata[j];
    end else begin : g_zero
      assign page_in[j] = 1'b0;
    end
  end

  for (genvar j = 0; j < PAGE_W; j++) begin : g_ev_page
    if (j < PAGE_BITS) begin : g_bit
      assign ev_page16[j] = ev_valid ? vic_page[j] : 1'b0;
    end else begin : g_zero
      assign ev_page16[j] = 1'b0;
    end
  end

  for (genvar j = 0; j < SLOT_W; j++) begin : g_slot
    if (j < SW) begin : g_bit
      assign slot4[j] = new_slot[j];
    end else begin : g_zero
      assign slot4[j] = 1'b0;
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign upd_go        = (state == ST_UPDATE) && (!m_axis_tvalid || m_axis_tready);

  // outcome of the walk
  always_comb begin
    cfg_ext = EW'(frames_in_use);
    if (cfg_ext == '0) begin
      eff_frames = ONE_EXT;
    end else if (cfg_ext > MAX_EXT) begin
      eff_frames = MAX_EXT;
    end else begin
      eff_frames = cfg_ext;
    end
    fill_ok   = !hit_found && (EW'(frames_filled) < eff_frames);
    limit_all = fill_ok;
    limit     = hit_found ? hit_rank : vic_rank;
    ev_valid  = !hit_found && !fill_ok && vic_found;
    set_valid = !hit_found && (fill_ok || !vic_found);
    if (hit_found) begin
      new_slot = hit_slot;
    end else if (fill_ok) begin
      new_slot = frames_filled[SW-1:0];
    end else if (vic_found) begin
      new_slot = vic_slot;
    end else begin
      new_slot = '0;
    end
    if (hit_found || fault_counter == '1) begin
      fault_next = fault_counter;
    end else begin
      fault_next = fault_counter + FAULT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (p_vld && p_idx == LAST) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (upd_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // page memory
  always_ff @(posedge clk) begin
    if (state == ST_SCAN && !issue_done) begin
      rd_page <= frame_page[idx];
    end
    if (upd_go && !hit_found) begin
      frame_page[new_slot] <= page;
    end
  end

  // walk over the frames
  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld      <= 1'b0;
      issue_done <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      p_vld      <= 1'b0;
      issue_done <= 1'b0;
    end else if (state == ST_SCAN) begin
      p_vld <= !issue_done;
      if (!issue_done && idx == LAST) begin
        issue_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      page      <= page_in;
      idx       <= '0;
      hit_found <= 1'b0;
      vic_found <= 1'b0;
      vic_rank  <= '0;
      vic_slot  <= '0;
      hit_slot  <= '0;
      hit_rank  <= '0;
    end else if (state == ST_SCAN) begin
      if (!issue_done) begin
        p_idx <= idx;
        if (idx != LAST) begin
          idx <= idx + SW'(1);
        end
      end
      if (p_vld && frame_valid[p_idx]) begin
        if (!hit_found && rd_page == page) begin
          hit_found <= 1'b1;
          hit_slot  <= p_idx;
          hit_rank  <= recency_rank[p_idx];
        end
        if (!vic_found || recency_rank[p_idx] > vic_rank) begin
          vic_found <= 1'b1;
          vic_slot  <= p_idx;
          vic_rank  <= recency_rank[p_idx];
          vic_page  <= rd_page;
        end
      end
    end
  end

  // frame state, recency and fault count
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_RESET;
      frame_valid   <= '0;
      frames_filled <= '0;
      fault_counter <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        recency_rank[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        frames_in_use <= cfg_wr_data;
      end
      if (upd_go) begin
        fault_counter <= fault_next;
        if (set_valid) begin
          frame_valid[new_slot] <= 1'b1;
          frames_filled <= fill_ok ? frames_filled + FW'(1) : FW'(1);
        end
        for (int i = 0; i < MAX_FRAMES; i++) begin
          if (SW'(i) == new_slot) begin
            recency_rank[i] <= '0;
          end else if (frame_valid[i] && (limit_all || recency_rank[i] < limit)) begin
            recency_rank[i] <= recency_rank[i] + SW'(1);
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (upd_go) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      m_axis_tdata <= {2'b00, fault_next, ev_page16, ev_valid, slot4, hit_found};
    end
  end

  a_accept_starts_walk: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> state == ST_SCAN)
    else $error("transfer accepted but walk not started");

  a_filled_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(frame_valid) == int'(frames_filled))
    else $error("filled count differs from valid frames");

  a_filled_bound: assert property (@(posedge clk) disable iff (rst)
    int'(frames_filled) <= MAX_FRAMES)
    else $error("filled count beyond frame table");

  a_hit_keeps_faults: assert property (@(posedge clk) disable iff (rst)
    upd_go && hit_found |=> fault_counter == $past(fault_counter))
    else $error("fault count moved on a hit");

  a_update_gives_result: assert property (@(posedge clk) disable iff (rst)
    upd_go |=> m_axis_tvalid && state == ST_IDLE)
    else $error("update without result");

endmodule

`default_nettype wire

FILE: dv/lru_page_replacement_test.sv
// ----------------------------------------------------------------------------
// lru_page_replacement_test
// Self-checking bench for the LRU page replacement engine. Page references go
// in through the slave stream and a bench-side LRU table predicts each
// result: hit flag, frame slot, evicted page and running fault count.
// Directed tests cover out-of-range frame counts, filling every frame,
// eviction and a frame count lowered below the filled frames. Random phases
// then draw references from working sets of several sizes under several
// frame settings, with random gaps on both streams in all but one phase.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement_test;
  import lru_pr_pkg::*;

  localparam int NFRAMES       = 16;
  localparam int SETTLE_CYCLES = 24;
  localparam int MAX_PRINTS    = 40;

  typedef struct {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               ev_valid;
    logic [PAGE_W-1:0]  ev_page;
    logic [FAULT_W-1:0] faults;
  } lru_outcome_t;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [PAGE_W-1:0]  s_axis_tdata  = '0;   // page_number
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_W-1:0]   m_axis_tdata;         // hit, frame_slot, evicted_valid,
                                            // evicted_page, fault_total
  logic               cfg_wr_en     = 1'b0;
  logic [CFG_W-1:0]   cfg_wr_data   = '0;

  // bench copy of the frame table
  logic [PAGE_W-1:0]  tbl_page [NFRAMES];
  logic               tbl_live [NFRAMES];
  int unsigned        tbl_age  [NFRAMES];
  int unsigned        tbl_filled;
  logic [FAULT_W-1:0] tbl_faults;
  logic [CFG_W-1:0]   frames_cfg;

  lru_outcome_t expected_outcomes[$];

  int  err_count;
  int  results_seen;
  int  hits_seen;
  int  evictions_seen;
  int  cfg_writes;
  bit  calm_mode;
  int  stall_left;

  lru_page_replacement #(
    .MAX_FRAMES(NFRAMES),
    .PAGE_BITS (PAGE_W)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // every valid frame younger than limit ages by one, then s becomes newest
  function automatic void make_newest(int unsigned s, int unsigned limit);
    for (int i = 0; i < NFRAMES; i++) begin
      if (tbl_live[i] && i != s && tbl_age[i] < limit) tbl_age[i]++;
    end
    tbl_age[s] = 0;
  endfunction

  function automatic lru_outcome_t lookup_page(logic [PAGE_W-1:0] pg);
    lru_outcome_t o;
    int unsigned  eff;
    int unsigned  slot;
    int unsigned  oldest;
    bit           found;
    o = '{hit: 1'b0, slot: '0, ev_valid: 1'b0, ev_page: '0, faults: '0};
    slot = 0;
    found = 0;
    eff = 32'(frames_cfg);
    if (eff < 1) eff = 1;
    if (eff > NFRAMES) eff = NFRAMES;
    for (int i = 0; i < NFRAMES; i++) begin
      if (!found && tbl_live[i] && tbl_page[i] == pg) begin
        found = 1;
        slot = i;
      end
    end
    if (found) begin
      o.hit = 1'b1;
      make_newest(slot, tbl_age[slot]);
    end else begin
      if (tbl_faults != '1) tbl_faults++;
      if (tbl_filled < eff && tbl_filled < NFRAMES) begin
        slot = tbl_filled;
        tbl_live[slot] = 1'b1;
        tbl_page[slot] = pg;
        tbl_filled++;
        make_newest(slot, NFRAMES);
      end else begin
        oldest = 0;
        found = 0;
        for (int i = 0; i < NFRAMES; i++) begin
          if (tbl_live[i] && (!found || tbl_age[i] > oldest)) begin
            oldest = tbl_age[i];
            slot = i;
            found = 1;
          end
        end
        if (found) begin
          o.ev_valid = 1'b1;
          o.ev_page = tbl_page[slot];
        end else begin
          slot = 0;
          tbl_live[0] = 1'b1;
          tbl_filled = 1;
        end
        tbl_page[slot] = pg;
        make_newest(slot, tbl_age[slot]);
      end
    end
    o.slot = slot[SLOT_W-1:0];
    o.faults = tbl_faults;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [FAULT_W-1:0] got,
                                 logic [FAULT_W-1:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("mismatch at result %0d, %s: got %h want %h", results_seen, what, got, want);
  endtask

  // receiver side, mostly ready with short and occasional long stalls
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (calm_mode) begin
      m_axis_tready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (r < 4) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(10, 60);
    end else begin
      m_axis_tready <= (r >= 30);
    end
  end

  // result checker
  always @(posedge clk) begin
    lru_outcome_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_outcomes.size() == 0) begin
        report_mismatch("unexpected transfer", m_axis_tdata[31:0], '0);
      end else begin
        want = expected_outcomes.pop_front();
        if (m_axis_tdata[0] !== want.hit)
          report_mismatch("hit", FAULT_W'(m_axis_tdata[0]), FAULT_W'(want.hit));
        if (m_axis_tdata[4:1] !== want.slot)
          report_mismatch("frame_slot", FAULT_W'(m_axis_tdata[4:1]), FAULT_W'(want.slot));
        if (m_axis_tdata[5] !== want.ev_valid)
          report_mismatch("evicted_valid", FAULT_W'(m_axis_tdata[5]),
                          FAULT_W'(want.ev_valid));
        if (m_axis_tdata[21:6] !== want.ev_page)
          report_mismatch("evicted_page", FAULT_W'(m_axis_tdata[21:6]),
                          FAULT_W'(want.ev_page));
        if (m_axis_tdata[53:22] !== want.faults)
          report_mismatch("fault_total", m_axis_tdata[53:22], want.faults);
        if (want.hit) hits_seen++;
        if (want.ev_valid) evictions_seen++;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_mode || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // valid stays high across back-to-back transfers
  task automatic send_page(input logic [PAGE_W-1:0] pg);
    int gap;
    lru_outcome_t o;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pg;
    do @(posedge clk); while (!s_axis_tready);
    o = lookup_page(pg);
    expected_outcomes = {expected_outcomes, o};
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] v);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    frames_cfg = v;
    cfg_writes++;
    cfg_wr_en <= 1'b0;
  endtask

  // zero frames acts as one: every new page replaces slot 0
  task automatic test_zero_frames();
    write_frames(5'd0);
    send_page(16'h0000);
    send_page(16'hffff);
    send_page(16'hffff);
  endtask

  task automatic test_two_frames();
    write_frames(5'd2);
    send_page(16'h5555);
    send_page(16'hffff);
    send_page(16'haaaa);
    send_page(16'h5555);
  endtask

  // above the built count acts as the built count; fill then evict
  task automatic test_fill_all();
    write_frames(5'd31);
    for (int i = 0; i < 14; i++) send_page(16'h0001 << i);
    send_page(16'h8000);
    send_page(16'h0004);
    send_page(16'h1234);
  endtask

  // lowering below the filled frames releases nothing
  task automatic test_lowered_frames();
    write_frames(5'd1);
    send_page(16'h4321);
    send_page(16'h0001);
    send_page(16'h8000);
  endtask

  task automatic test_random_mix(int n_items, logic [CFG_W-1:0] frames, int pool_size,
                                 bit no_gaps, bit pause_midway);
    logic [PAGE_W-1:0] pool[$];
    logic [PAGE_W-1:0] pg;
    write_frames(frames);
    calm_mode = no_gaps;
    for (int i = 0; i < pool_size; i++) pool = {pool, PAGE_W'($urandom())};
    for (int i = 0; i < n_items; i++) begin
      if (pause_midway && i == n_items / 2) drain_results();
      if ($urandom_range(0, 99) < 85)
        pg = pool[$urandom_range(0, pool_size - 1)];
      else
        pg = PAGE_W'($urandom());
      send_page(pg);
    end
    calm_mode = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < NFRAMES; i++) begin
      tbl_page[i] = '0;
      tbl_live[i] = 1'b0;
      tbl_age[i] = 0;
    end
    tbl_filled = 0;
    tbl_faults = '0;
    frames_cfg = FRAMES_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_zero_frames();
    test_two_frames();
    test_fill_all();
    test_lowered_frames();
    test_random_mix(100, 5'd1, 12, 1'b0, 1'b0);
    test_random_mix(100, 5'd16, 20, 1'b0, 1'b1);
    test_random_mix(100, 5'd0, 24, 1'b1, 1'b0);
    test_random_mix(100, 5'd31, 17, 1'b0, 1'b0);
    test_random_mix(100, CFG_W'($urandom_range(2, 15)), 40, 1'b0, 1'b0);
    test_random_mix(100, 5'd16, 18, 1'b0, 1'b0);
    drain_results();

    $display("%0d page references checked: %0d hits, %0d evictions, %0d frame count writes",
             results_seen, hits_seen, evictions_seen, cfg_writes);
    if (err_count == 0 && expected_outcomes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timed out with %0d results outstanding", expected_outcomes.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/lru_pr_pkg.sv
rtl/lru_page_replacement.sv
dv/lru_page_replacement_test.sv
